// ----- sv/sme_pkg.sv -----
// Package with shared types, constants and codes for the stack machine executor.
`default_nettype none
package sme_pkg;
   localparam int STACK_DEPTH_DEF = 8;
   localparam int NEST_DEPTH_DEF = 8;
   localparam int DATA_W = 32;
   localparam int DEPTH_W = 4;
   localparam int ERR_W = 3;

   localparam logic [7:0] MODE_PUSH = 8'd0;
   localparam logic [7:0] MODE_PRIM = 8'd1;

   typedef enum logic [7:0] {
      OP_HALT = 8'd0, OP_DUP = 8'd1, OP_POP = 8'd2, OP_ADD = 8'd3, OP_SUB = 8'd4,
      OP_MUL = 8'd5, OP_DIV = 8'd6, OP_MOD = 8'd7, OP_AND = 8'd8, OP_OR = 8'd9,
      OP_NOT = 8'd10, OP_EQ = 8'd11, OP_LT = 8'd12, OP_GT = 8'd13, OP_IF = 8'd14,
      OP_ELSE = 8'd15, OP_ENDIF = 8'd16
   } opcode_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2, ERR_DIVZ = 3'd3,
      ERR_TYPE = 3'd4, ERR_NEST = 3'd5
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_DIV, ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_done_use;
      logic resp_take;
   } cmd_type;

   typedef struct packed {
      logic is_div;
      logic div_busy;
   } status_type;
endpackage
`default_nettype wire

// ----- sv/sme_ctrl.sv -----
// Controller state machine for the stack machine executor.
`default_nettype none
module sme_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire sme_pkg::status_type status,
   output sme_pkg::cmd_type        cmd
);
   sme_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sme_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sme_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.is_div ? sme_pkg::ST_DIV : sme_pkg::ST_RESP;
            end
         end
         sme_pkg::ST_DIV: begin
            if (!status.div_busy) begin
               state_in = sme_pkg::ST_RESP;
            end
         end
         sme_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = req_valid ? (status.is_div ? sme_pkg::ST_DIV : sme_pkg::ST_RESP)
                                    : sme_pkg::ST_IDLE;
            end
         end
         default: state_in = sme_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd = '0;
      case (state_ff)
         sme_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
            cmd.div_start = req_valid && status.is_div;
         end
         sme_pkg::ST_DIV: begin
            cmd.div_done_use = !status.div_busy;
         end
         sme_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            cmd.resp_take = !rsp_stall;
            cmd.load = !rsp_stall && req_valid;
            cmd.div_start = !rsp_stall && req_valid && status.is_div;
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == sme_pkg::ST_DIV |-> req_stall)
      else $error("input taken during division");
   assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall) || cmd.load)
      else $error("transfer without load");
endmodule
`default_nettype wire

// ----- sv/sme_div.sv -----
// Iterative signed restoring divider, one quotient bit per cycle.
`default_nettype none
module sme_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [sme_pkg::DATA_W-1:0]  dividend,
   input  wire logic [sme_pkg::DATA_W-1:0]  divisor,
   output logic                             busy,
   output logic [sme_pkg::DATA_W-1:0]       quotient,
   output logic [sme_pkg::DATA_W-1:0]       remainder
);
   localparam int W = sme_pkg::DATA_W;
   localparam int CW = $clog2(W + 1);
   logic [CW-1:0] count_ff;
   logic [W-1:0] q_ff, d_ff;
   logic [W:0] r_ff;
   logic neg_q_ff, neg_r_ff;
   logic [W:0] shifted, diff;

   assign busy = (count_ff != '0);
   assign shifted = {r_ff[W-1:0], q_ff[W-1]};
   assign diff = shifted - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= CW'(W);
      end else if (busy) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
         d_ff <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
         r_ff <= '0;
         neg_q_ff <= dividend[W-1] ^ divisor[W-1];
         neg_r_ff <= dividend[W-1];
      end else if (busy) begin
         if (!diff[W]) begin
            r_ff <= diff;
            q_ff <= {q_ff[W-2:0], 1'b1};
         end else begin
            r_ff <= shifted;
            q_ff <= {q_ff[W-2:0], 1'b0};
         end
      end
   end

   assign quotient = neg_q_ff ? (~q_ff + 1'b1) : q_ff;
   assign remainder = neg_r_ff ? (~r_ff[W-1:0] + 1'b1) : r_ff[W-1:0];
endmodule
`default_nettype wire

// ----- sv/sme_dp.sv -----
// Datapath of the stack machine executor: stack, nesting state and result register.
`default_nettype none
module sme_dp #(
   parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
   parameter int NEST_DEPTH = sme_pkg::NEST_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sme_pkg::cmd_type            cmd,
   output sme_pkg::status_type              status,
   input  wire logic [7:0]                  req_mode,
   input  wire logic [7:0]                  req_value,
   output logic signed [sme_pkg::DATA_W-1:0] rsp_top_value,
   output logic [sme_pkg::DEPTH_W-1:0]      rsp_depth,
   output logic                             rsp_halted,
   output logic                             rsp_skipped,
   output logic [sme_pkg::ERR_W-1:0]        rsp_error
);
   localparam int W = sme_pkg::DATA_W;
   localparam int SW = $clog2(STACK_DEPTH + 1);
   localparam int SI = $clog2(STACK_DEPTH);
   localparam int LW = $clog2(NEST_DEPTH + 1);
   localparam int NI = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

   logic [W-1:0] stack_ff [STACK_DEPTH];
   logic [SW-1:0] count_ff, count_in;
   logic halt_ff, halt_in;
   logic [LW-1:0] level_ff, level_in;
   logic [NEST_DEPTH-1:0] cond_ff, cond_in, else_ff, else_in;
   logic wr_en;
   logic [SI-1:0] wr_idx;
   logic [W-1:0] wr_data;
   logic skipped_in;
   logic [sme_pkg::ERR_W-1:0] err_in;
   logic [7:0] op_ff;
   logic [SW-1:0] dcount_ff;

   logic [W-1:0] a, b, top;
   logic [SI-1:0] i1, i2;
   logic [NEST_DEPTH-1:0] good;
   logic act_all, act_top;
   logic is_prim, is_binary, is_divop;
   logic [W-1:0] quo, rem;
   logic div_busy;
   logic [2*W-1:0] prod;
   logic [NI-1:0] bit_idx, top_idx;

   assign i1 = SI'(count_ff - 1'b1);
   assign i2 = SI'(count_ff - 2'd2);
   assign b = stack_ff[i1];
   assign a = stack_ff[i2];
   assign good = cond_ff ^ else_ff;
   assign prod = a * b;

   always_comb begin
      act_all = 1'b1;
      act_top = 1'b1;
      for (int l = 0; l < NEST_DEPTH; l++) begin
         if (LW'(l) < level_ff && !good[l]) act_all = 1'b0;
         if (LW'(l) + 1'b1 < level_ff && !good[l]) act_top = 1'b0;
      end
   end

   assign is_prim = (req_mode == sme_pkg::MODE_PRIM);
   assign is_binary = is_prim && (req_value inside {[8'd3:8'd9], [8'd11:8'd13]});
   assign is_divop = is_prim && (req_value == sme_pkg::OP_DIV || req_value == sme_pkg::OP_MOD);
   assign status.is_div = !halt_ff && act_all && is_divop && count_ff >= SW'(2) && b != '0;
   assign status.div_busy = div_busy;
   assign bit_idx = NI'(level_ff);
   assign top_idx = NI'(level_ff - 1'b1);

   sme_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(a), .divisor(b), .busy(div_busy), .quotient(quo), .remainder(rem)
   );

   always_comb begin
      count_in = count_ff;
      halt_in = halt_ff;
      level_in = level_ff;
      cond_in = cond_ff;
      else_in = else_ff;
      wr_en = 1'b0;
      wr_idx = i2;
      wr_data = '0;
      skipped_in = 1'b0;
      err_in = sme_pkg::ERR_NONE;
      if (halt_ff) begin
         skipped_in = 1'b1;
      end else if (is_prim && req_value == sme_pkg::OP_IF) begin
         skipped_in = !act_all;
         if (level_ff >= LW'(NEST_DEPTH)) begin
            err_in = sme_pkg::ERR_NEST;
         end else if (act_all && count_ff == '0) begin
            err_in = sme_pkg::ERR_UNDER;
         end else begin
            cond_in[bit_idx] = act_all && b != '0;
            else_in[bit_idx] = 1'b0;
            level_in = level_ff + 1'b1;
         end
      end else if (is_prim && (req_value == sme_pkg::OP_ELSE
                               || req_value == sme_pkg::OP_ENDIF)) begin
         if (level_ff != '0) begin
            skipped_in = !act_top;
            if (req_value == sme_pkg::OP_ELSE) else_in[top_idx] = 1'b1;
            else level_in = level_ff - 1'b1;
         end
      end else if (!act_all) begin
         skipped_in = 1'b1;
      end else if (req_mode == sme_pkg::MODE_PUSH) begin
         if (count_ff >= SW'(STACK_DEPTH)) begin
            err_in = sme_pkg::ERR_OVER;
         end else begin
            wr_en = 1'b1;
            wr_idx = SI'(count_ff);
            wr_data = {{(W-8){1'b0}}, req_value};
            count_in = count_ff + 1'b1;
         end
      end else if (is_prim) begin
         case (req_value)
            sme_pkg::OP_HALT: halt_in = 1'b1;
            sme_pkg::OP_DUP: begin
               if (count_ff == '0) err_in = sme_pkg::ERR_UNDER;
               else if (count_ff >= SW'(STACK_DEPTH)) err_in = sme_pkg::ERR_OVER;
               else begin
                  wr_en = 1'b1;
                  wr_idx = SI'(count_ff);
                  wr_data = b;
                  count_in = count_ff + 1'b1;
               end
            end
            sme_pkg::OP_POP: begin
               if (count_ff == '0) err_in = sme_pkg::ERR_UNDER;
               else count_in = count_ff - 1'b1;
            end
            sme_pkg::OP_NOT: begin
               if (count_ff == '0) err_in = sme_pkg::ERR_UNDER;
               else begin
                  wr_en = 1'b1;
                  wr_idx = i1;
                  wr_data = {{(W-1){1'b0}}, b == '0};
               end
            end
            default: begin
               if (is_binary) begin
                  if (count_ff < SW'(2)) err_in = sme_pkg::ERR_UNDER;
                  else if (is_divop && b == '0) err_in = sme_pkg::ERR_DIVZ;
                  else begin
                     wr_en = !is_divop;
                     count_in = count_ff - 1'b1;
                     case (req_value)
                        sme_pkg::OP_ADD: wr_data = a + b;
                        sme_pkg::OP_SUB: wr_data = a - b;
                        sme_pkg::OP_MUL: wr_data = prod[W-1:0];
                        sme_pkg::OP_AND: wr_data = {{(W-1){1'b0}},
                                                    a == 32'd1 && b == 32'd1};
                        sme_pkg::OP_OR: wr_data = {{(W-1){1'b0}},
                                                   a == 32'd1 || b == 32'd1};
                        sme_pkg::OP_EQ: wr_data = {{(W-1){1'b0}}, a == b};
                        sme_pkg::OP_LT: wr_data = {{(W-1){1'b0}},
                                                   $signed(a) < $signed(b)};
                        sme_pkg::OP_GT: wr_data = {{(W-1){1'b0}},
                                                   $signed(a) > $signed(b)};
                        default: wr_data = '0;
                     endcase
                  end
               end
            end
         endcase
      end else begin
         err_in = sme_pkg::ERR_TYPE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         halt_ff <= 1'b0;
         level_ff <= '0;
         cond_ff <= '0;
         else_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= count_in;
         halt_ff <= halt_in;
         level_ff <= level_in;
         cond_ff <= cond_in;
         else_ff <= else_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (wr_en) stack_ff[wr_idx] <= wr_data;
         op_ff <= req_value;
         dcount_ff <= count_in;
         rsp_depth <= sme_pkg::DEPTH_W'(count_in);
         rsp_halted <= halt_in;
         rsp_skipped <= skipped_in;
         rsp_error <= err_in;
      end else if (cmd.div_done_use) begin
         stack_ff[SI'(dcount_ff - 1'b1)] <= (op_ff == sme_pkg::OP_DIV) ? quo : rem;
      end
   end

   assign top = stack_ff[i1];
   assign rsp_top_value = (count_ff != '0) ? top : '0;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= SW'(STACK_DEPTH))
      else $error("stack count out of range");
   assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(NEST_DEPTH))
      else $error("nesting level out of range");
   assert property (@(posedge clock) disable iff (reset)
      $past(halt_ff) && !$past(reset) |-> halt_ff)
      else $error("halt cleared");
endmodule
`default_nettype wire

// ----- sv/stack_machine_executor.sv -----
// Top level of the stack machine executor.
// Instruction words arrive on the req_ channel (req_mode, req_value) with
// valid/stall handshaking; one result per word leaves on the rsp_ channel.
// A transfer takes place at a clock edge where valid is high and stall is low.
// Most words present their registered result in the cycle after the transfer.
// DIV and MOD with valid operands run through a radix-2 divider of 32 quotient
// steps; their result is presented once that unit is no longer busy.
// One word is in flight at a time; a new word is accepted in the same cycle
// its predecessor's result transfers, so simple words sustain one per cycle while the receiver does not stall.
// While the receiver stalls, the result holds and the input channel stalls.
// Synchronous reset empties the stack, clears halt and all branch levels.
// Stack entries hold no reset value; only written entries are ever read.
`default_nettype none
module stack_machine_executor #(
   parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
   parameter int NEST_DEPTH = sme_pkg::NEST_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_mode,
   input  wire logic [7:0]                   req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [sme_pkg::DATA_W-1:0] rsp_top_value,
   output logic [sme_pkg::DEPTH_W-1:0]       rsp_depth,
   output logic                              rsp_halted,
   output logic                              rsp_skipped,
   output logic [sme_pkg::ERR_W-1:0]         rsp_error
);
   sme_pkg::cmd_type cmd;
   sme_pkg::status_type status;

   sme_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .cmd(cmd)
   );

   sme_dp #(.STACK_DEPTH(STACK_DEPTH), .NEST_DEPTH(NEST_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_mode(req_mode), .req_value(req_value),
      .rsp_top_value(rsp_top_value), .rsp_depth(rsp_depth), .rsp_halted(rsp_halted),
      .rsp_skipped(rsp_skipped), .rsp_error(rsp_error)
   );
endmodule
`default_nettype wire
